>>> hdl/mltd_pkg.sv
// Package with the types and constants shared by the deframer modules.
package mltd_pkg;

    localparam int unsigned LEN_W = 31;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd5242881;

    localparam logic [31:0] SYNC_WORD = 32'h626F6B69;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_TYPE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] msg_type;
        logic       payload_valid;
        logic       last;
        logic       bad_length;
    } t_result;

    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = SYNC_WORD[31:24];
            2'd1:    b = SYNC_WORD[23:16];
            2'd2:    b = SYNC_WORD[15:8];
            default: b = SYNC_WORD[7:0];
        endcase
        return b;
    endfunction

endpackage

>>> hdl/mltd_front.sv
// Front end: frame parser that accepts input bytes and classifies them into result items.
module mltd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_space,
    input  logic                        i_cfg_wr_en,
    input  logic [mltd_pkg::LEN_W-1:0]  i_cfg_wr_data,
    output logic                        o_ready,
    output logic                        o_push,
    output mltd_pkg::t_result           o_result
);

    mltd_pkg::t_phase            r_phase, n_phase;
    logic [1:0]                  r_match_count, n_match_count;
    logic [23:0]                 r_length_shift, n_length_shift;
    logic [1:0]                  r_length_count, n_length_count;
    logic [mltd_pkg::LEN_W-1:0]  r_bytes_remaining, n_bytes_remaining;
    logic [7:0]                  r_frame_type, n_frame_type;
    logic [mltd_pkg::LEN_W-1:0]  r_max_len;
    logic [31:0]                 full_len;
    logic                        accept;

    assign o_ready  = i_space;
    assign accept   = i_valid && i_space;
    assign full_len = {r_length_shift, i_data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= mltd_pkg::PH_HUNT;
            r_match_count     <= '0;
            r_length_shift    <= '0;
            r_length_count    <= '0;
            r_bytes_remaining <= '0;
            r_frame_type      <= '0;
            r_max_len         <= mltd_pkg::MAX_LEN_RESET;
        end else begin
            r_phase           <= n_phase;
            r_match_count     <= n_match_count;
            r_length_shift    <= n_length_shift;
            r_length_count    <= n_length_count;
            r_bytes_remaining <= n_bytes_remaining;
            r_frame_type      <= n_frame_type;
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    always_comb begin
        n_phase           = r_phase;
        n_match_count     = r_match_count;
        n_length_shift    = r_length_shift;
        n_length_count    = r_length_count;
        n_bytes_remaining = r_bytes_remaining;
        n_frame_type      = r_frame_type;
        o_push            = 1'b0;
        o_result          = '0;
        if (accept) begin
            case (r_phase)
                mltd_pkg::PH_HUNT: begin
                    if (i_data_byte == mltd_pkg::sync_byte(r_match_count)) begin
                        if (r_match_count == 2'd3) begin
                            n_phase        = mltd_pkg::PH_LENGTH;
                            n_match_count  = '0;
                            n_length_shift = '0;
                            n_length_count = '0;
                        end else begin
                            n_match_count = r_match_count + 2'd1;
                        end
                    end else begin
                        n_match_count = (i_data_byte == mltd_pkg::sync_byte(2'd0)) ? 2'd1 : 2'd0;
                    end
                end
                mltd_pkg::PH_LENGTH: begin
                    n_length_shift = full_len[23:0];
                    if (r_length_count != 2'd3) begin
                        n_length_count = r_length_count + 2'd1;
                    end else begin
                        n_length_count = '0;
                        if (full_len == 32'd0 || full_len[31] ||
                            full_len > {1'b0, r_max_len}) begin
                            n_phase             = mltd_pkg::PH_HUNT;
                            n_match_count       = '0;
                            n_length_shift      = '0;
                            n_bytes_remaining   = '0;
                            o_push              = 1'b1;
                            o_result.last       = 1'b1;
                            o_result.bad_length = 1'b1;
                        end else begin
                            n_bytes_remaining = full_len[mltd_pkg::LEN_W-1:0] - 31'd1;
                            n_phase           = mltd_pkg::PH_TYPE;
                        end
                    end
                end
                mltd_pkg::PH_TYPE: begin
                    n_frame_type = i_data_byte;
                    if (r_bytes_remaining == '0) begin
                        n_phase           = mltd_pkg::PH_HUNT;
                        n_match_count     = '0;
                        n_length_shift    = '0;
                        n_length_count    = '0;
                        n_bytes_remaining = '0;
                        o_push            = 1'b1;
                        o_result.msg_type = i_data_byte;
                        o_result.last     = 1'b1;
                    end else begin
                        n_phase = mltd_pkg::PH_PAYLOAD;
                    end
                end
                default: begin
                    o_push                 = 1'b1;
                    o_result.payload_byte  = i_data_byte;
                    o_result.msg_type      = r_frame_type;
                    o_result.payload_valid = 1'b1;
                    o_result.last          = (r_bytes_remaining <= 31'd1);
                    if (r_bytes_remaining <= 31'd1) begin
                        n_phase           = mltd_pkg::PH_HUNT;
                        n_match_count     = '0;
                        n_length_shift    = '0;
                        n_length_count    = '0;
                        n_bytes_remaining = '0;
                    end else begin
                        n_bytes_remaining = r_bytes_remaining - 31'd1;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/mltd_queue.sv
// Short queue of result items between the parser and the output stage.
module mltd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mltd_pkg::t_result  i_item,
    input  logic               i_pop,
    output logic               o_space,
    output logic               o_avail,
    output mltd_pkg::t_result  o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mltd_pkg::t_result  r_entries [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_space = (r_count != CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_entries[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/mltd_back.sv
// Back end: output register that drains the queue onto the result channel.
module mltd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  mltd_pkg::t_result  i_item,
    input  logic               i_ready,
    output logic               o_pop,
    output logic               o_valid,
    output mltd_pkg::t_result  o_item
);

    logic               r_valid;
    mltd_pkg::t_result  r_item;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hdl/magic_length_type_deframer.sv
// Top level of the sync-word, length and type framed byte-stream deframer.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_data_byte
//  result    out        o_valid / i_ready   o_payload_byte, o_msg_type, o_payload_valid,
//                                           o_last, o_bad_length
//  config    in         i_cfg_wr_en         i_cfg_wr_data
//
// One byte is accepted per cycle while the result queue has room.
// A result passes through the queue and then the output register on its way to the outputs.
// The queue of QUEUE_DEPTH items lets the parser keep taking bytes while a result waits.
// Reset is synchronous; it returns the parser to the hunt and empties the queue.
module magic_length_type_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_payload_byte,
    output logic [7:0]                  o_msg_type,
    output logic                        o_payload_valid,
    output logic                        o_last,
    output logic                        o_bad_length,
    input  logic                        i_cfg_wr_en,
    input  logic [mltd_pkg::LEN_W-1:0]  i_cfg_wr_data
);

    logic               q_space;
    logic               q_avail;
    logic               q_pop;
    logic               f_push;
    mltd_pkg::t_result  f_result;
    mltd_pkg::t_result  q_item;
    mltd_pkg::t_result  out_item;

    mltd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_space       (q_space),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_ready       (o_ready),
        .o_push        (f_push),
        .o_result      (f_result)
    );

    mltd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_result),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    mltd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_item  (q_item),
        .i_ready (i_ready),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_item  (out_item)
    );

    assign o_payload_byte  = out_item.payload_byte;
    assign o_msg_type      = out_item.msg_type;
    assign o_payload_valid = out_item.payload_valid;
    assign o_last          = out_item.last;
    assign o_bad_length    = out_item.bad_length;

endmodule

>>> hdl/mltd_checker.sv
// Port-level checker for the deframer and its bind to the top level.
module mltd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_msg_type,
    input logic       o_payload_valid,
    input logic       o_last,
    input logic       o_bad_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_payload_byte) &&
            $stable(o_msg_type) && $stable(o_last) && $stable(o_bad_length))
        else $error("Stalled result item changed.");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_length |-> o_last && !o_payload_valid &&
            o_payload_byte == 8'd0 && o_msg_type == 8'd0)
        else $error("Bad-length item has wrong fields.");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_payload_valid |-> o_last && o_payload_byte == 8'd0)
        else $error("Item without payload is not a final zero item.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

endmodule

bind magic_length_type_deframer mltd_checker u_mltd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_payload_byte  (o_payload_byte),
    .o_msg_type      (o_msg_type),
    .o_payload_valid (o_payload_valid),
    .o_last          (o_last),
    .o_bad_length    (o_bad_length)
);

>>> tb/magic_length_type_deframer_test.sv
// Testbench for the sync-word, length and type framed byte-stream deframer.
module magic_length_type_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [7:0]                 i_data_byte = 8'd0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [7:0]                 o_payload_byte;
    logic [7:0]                 o_msg_type;
    logic                       o_payload_valid;
    logic                       o_last;
    logic                       o_bad_length;
    logic                       i_cfg_wr_en = 1'b0;
    logic [mltd_pkg::LEN_W-1:0] i_cfg_wr_data = '0;

    magic_length_type_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_payload_byte  (o_payload_byte),
        .o_msg_type      (o_msg_type),
        .o_payload_valid (o_payload_valid),
        .o_last          (o_last),
        .o_bad_length    (o_bad_length),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the parser state.
    mltd_pkg::t_phase           parse_phase = mltd_pkg::PH_HUNT;
    logic [1:0]                 sync_count = 2'd0;
    logic [31:0]                len_acc = 32'd0;
    logic [1:0]                 len_count = 2'd0;
    logic [mltd_pkg::LEN_W-1:0] payload_left = '0;
    logic [7:0]                 frame_type = 8'd0;
    logic [mltd_pkg::LEN_W-1:0] max_len = mltd_pkg::MAX_LEN_RESET;

    mltd_pkg::t_result expected_results[$];
    int                mismatch_count = 0;
    int                bytes_sent = 0;
    bit                quiet = 1'b0;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    task automatic add_expected(input mltd_pkg::t_result r);
        expected_results = {expected_results, r};
    endtask

    task automatic return_to_hunt();
        parse_phase  = mltd_pkg::PH_HUNT;
        sync_count   = 2'd0;
        len_acc      = 32'd0;
        len_count    = 2'd0;
        payload_left = '0;
    endtask

    task automatic advance_parser(input logic [7:0] b);
        mltd_pkg::t_result r;
        logic              is_last;
        r = '0;
        case (parse_phase)
            mltd_pkg::PH_HUNT: begin
                if (b == mltd_pkg::SYNC_WORD[(3 - sync_count) * 8 +: 8]) begin
                    if (sync_count == 2'd3) begin
                        parse_phase = mltd_pkg::PH_LENGTH;
                        sync_count  = 2'd0;
                        len_acc     = 32'd0;
                        len_count   = 2'd0;
                    end else begin
                        sync_count = sync_count + 2'd1;
                    end
                end else begin
                    sync_count = (b == mltd_pkg::SYNC_WORD[31:24]) ? 2'd1 : 2'd0;
                end
            end
            mltd_pkg::PH_LENGTH: begin
                len_acc = {len_acc[23:0], b};
                if (len_count != 2'd3) begin
                    len_count = len_count + 2'd1;
                end else begin
                    len_count = 2'd0;
                    if (len_acc == 32'd0 || len_acc[31] || len_acc > {1'b0, max_len}) begin
                        return_to_hunt();
                        r.last       = 1'b1;
                        r.bad_length = 1'b1;
                        add_expected(r);
                    end else begin
                        payload_left = len_acc[mltd_pkg::LEN_W-1:0] - 1'b1;
                        parse_phase  = mltd_pkg::PH_TYPE;
                    end
                end
            end
            mltd_pkg::PH_TYPE: begin
                frame_type = b;
                if (payload_left == '0) begin
                    return_to_hunt();
                    r.msg_type = frame_type;
                    r.last     = 1'b1;
                    add_expected(r);
                end else begin
                    parse_phase = mltd_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                is_last         = (payload_left <= 1);
                r.payload_byte  = b;
                r.msg_type      = frame_type;
                r.payload_valid = 1'b1;
                r.last          = is_last;
                add_expected(r);
                if (is_last) begin
                    return_to_hunt();
                end else begin
                    payload_left = payload_left - 1'b1;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        advance_parser(b);
    endtask

    task automatic send_sync();
        for (int i = 3; i >= 0; i--) begin
            send_byte(mltd_pkg::SYNC_WORD[i * 8 +: 8]);
        end
    endtask

    task automatic send_length(input logic [31:0] v);
        for (int i = 3; i >= 0; i--) begin
            send_byte(v[i * 8 +: 8]);
        end
    endtask

    // Sync word and length; if good, type and payload bytes to frame end.
    task automatic send_frame(input logic [31:0] len_field);
        send_sync();
        send_length(len_field);
        if (parse_phase == mltd_pkg::PH_TYPE) begin
            send_byte($urandom_range(0, 255));
        end
        while (parse_phase == mltd_pkg::PH_PAYLOAD) begin
            send_byte($urandom_range(0, 255));
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [mltd_pkg::LEN_W-1:0] v);
        while (parse_phase != mltd_pkg::PH_HUNT) begin
            send_byte($urandom_range(0, 255));
        end
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        max_len = v;
    endtask

    // Mostly well-formed frames, some of bad length; with noise allowed,
    // also junk, partial sync words and frames cut off inside the length.
    task automatic run_random_frames(input int n_bytes, input bit allow_noise);
        int          target;
        int          kind;
        int          k;
        int          lim;
        logic [31:0] len_field;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 9);
            lim  = (max_len < 30) ? max_len : 30;
            if (allow_noise && kind == 0) begin
                k = $urandom_range(0, 3);
                for (int i = 3; i > 3 - k; i--) begin
                    send_byte(mltd_pkg::SYNC_WORD[i * 8 +: 8]);
                end
                k = $urandom_range(1, 8);
                repeat (k) send_byte($urandom_range(0, 255));
            end else if (allow_noise && kind == 1) begin
                send_sync();
                send_byte($urandom_range(1, 255));
                k = $urandom_range(0, 2);
                repeat (k) send_byte($urandom_range(0, 255));
            end else if (kind == 2) begin
                case ($urandom_range(0, 2))
                    0:       len_field = 32'd0;
                    1:       len_field = 32'h8000_0000 | $urandom;
                    default: len_field = {1'b0, max_len} + 32'd1;
                endcase
                send_frame(len_field);
            end else begin
                if (max_len <= 300 && $urandom_range(0, 9) == 0) begin
                    len_field = {1'b0, max_len};
                end else begin
                    len_field = $urandom_range(1, lim);
                end
                send_frame(len_field);
            end
        end
    endtask

    task automatic test_directed();
        send_byte(mltd_pkg::SYNC_WORD[31:24]);
        send_sync();
        send_length(32'd0);
        send_sync();
        send_length(32'd1);
        send_byte(8'hFF);
        send_sync();
        send_length(32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_for_results();
    endtask

    task automatic test_small_max();
        write_max_len(31'd300);
        run_random_frames(150, 1'b1);
    endtask

    task automatic test_pause_mid_stream();
        run_random_frames(60, 1'b1);
        wait_for_results();
        run_random_frames(60, 1'b1);
    endtask

    task automatic test_min_max();
        write_max_len(31'd1);
        run_random_frames(100, 1'b1);
    endtask

    task automatic test_full_max();
        write_max_len(31'h7FFF_FFFF);
        run_random_frames(100, 1'b0);
    endtask

    task automatic test_quiet_tail();
        write_max_len(mltd_pkg::MAX_LEN_RESET);
        quiet = 1'b1;
        run_random_frames(100, 1'b0);
        wait_for_results();
    endtask

    initial begin : result_sink
        int n;
        forever begin
            if (quiet) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 16);
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                n = $urandom_range(1, 40);
                i_ready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        mltd_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("result with no item expected");
            end else begin
                want = expected_results.pop_front();
                if (o_payload_byte !== want.payload_byte || o_msg_type !== want.msg_type ||
                    o_payload_valid !== want.payload_valid || o_last !== want.last ||
                    o_bad_length !== want.bad_length) begin
                    flag_mismatch($sformatf(
                        "expected byte=%h type=%h pv=%b last=%b bad=%b, got %h %h %b %b %b",
                        want.payload_byte, want.msg_type, want.payload_valid, want.last,
                        want.bad_length, o_payload_byte, o_msg_type, o_payload_valid,
                        o_last, o_bad_length));
                end
            end
        end
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_small_max();
        test_pause_mid_stream();
        test_min_max();
        test_full_max();
        test_quiet_tail();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mltd_pkg.sv
hdl/mltd_front.sv
hdl/mltd_queue.sv
hdl/mltd_back.sv
hdl/magic_length_type_deframer.sv
hdl/mltd_checker.sv
tb/magic_length_type_deframer_test.sv
